[design/rotated_bitplane_pixel_plotter_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bit-plane pixel plotter
// Concurrent checks clocked on clk and disabled while rst_n is low; empty
// bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BITPLANE_PIXEL_PLOTTER_CORE_MACROS_SVH
`define ROTATED_BITPLANE_PIXEL_PLOTTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every edge out of reset
`define RBPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen out of reset
`define RBPP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBPP_ASSERT(lbl, prop, msg)
`define RBPP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[design/rbpp_pkg.sv]
// ----------------------------------------------------------------------------
// rbpp_pkg
// Shared types, codes and constants of the bit-plane pixel plotter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbpp_pkg;

    // Default panel geometry
    localparam int DEF_PANEL_WIDTH  = 240;
    localparam int DEF_PANEL_HEIGHT = 416;

    // Stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_DATA_W = 2;

    // Operation selector carried on tuser
    typedef enum logic [1:0] {
        FUNC_PLOT = 2'd0,
        FUNC_FILL = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic CFG_MONO_MODE = 1'b0;
    localparam logic CFG_ROTATION  = 1'b1;

    // Quarter-turn codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Named colours and gray levels
    localparam logic [15:0] COLOR_BLACK = 16'h0000;
    localparam logic [15:0] COLOR_DARK  = 16'h7BEF;
    localparam logic [15:0] COLOR_LIGHT = 16'hC618;
    localparam logic [9:0]  LEVEL_ONE   = 10'd1;
    localparam logic [9:0]  LEVEL_TWO   = 10'd2;
    localparam logic [9:0]  LEVEL_THREE = 10'd3;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;
    localparam logic [7:0] MASK_MSB   = 8'h80;

    // Controller states
    typedef enum logic [3:0] {
        CS_IDLE,
        CS_PLOT_ROT,
        CS_PLOT_MUL,
        CS_PLOT_ADDR,
        CS_PLOT_RD,
        CS_PLOT_WR,
        CS_FILL,
        CS_READ_RD,
        CS_READ_WAIT,
        CS_DONE
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rot_en;
        logic mul_en;
        logic addr_en;
        logic rd_plot;
        logic wr_plot;
        logic fill_wr;
        logic rd_index;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic plot_ok;
        logic fill_last;
        logic out_free;
    } dp_status_t;

endpackage

[design/rbpp_ctrl.sv]
// ----------------------------------------------------------------------------
// rbpp_ctrl
// Sequencer of the plotter: takes one item at a time and steps the datapath
// through the plot, fill or read sequence, then hands the result over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotated_bitplane_pixel_plotter_core_macros.svh"

module rbpp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic [1:0]             s_tuser,
    output logic                   s_tready,
    input  rbpp_pkg::dp_status_t   status,
    output rbpp_pkg::dp_cmd_t      cmd
);
    import rbpp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    func_t       func_in;

    assign func_in = func_t'(s_tuser);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    case (func_in)
                        FUNC_PLOT: state_next = CS_PLOT_ROT;
                        FUNC_FILL: state_next = CS_FILL;
                        FUNC_READ: state_next = CS_READ_RD;
                        default:   state_next = CS_DONE;
                    endcase
                end
            end
            CS_PLOT_ROT:
            begin
                cmd.rot_en = 1'b1;
                state_next = CS_PLOT_MUL;
            end
            CS_PLOT_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = CS_PLOT_ADDR;
            end
            CS_PLOT_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = CS_PLOT_RD;
            end
            CS_PLOT_RD:
            begin
                // Drop out-of-bounds plots without touching the planes
                if (status.plot_ok)
                begin
                    cmd.rd_plot = 1'b1;
                    state_next  = CS_PLOT_WR;
                end
                else
                begin
                    state_next = CS_DONE;
                end
            end
            CS_PLOT_WR:
            begin
                cmd.wr_plot = 1'b1;
                state_next  = CS_DONE;
            end
            CS_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last)
                begin
                    state_next = CS_DONE;
                end
            end
            CS_READ_RD:
            begin
                cmd.rd_index = 1'b1;
                state_next   = CS_READ_WAIT;
            end
            CS_READ_WAIT:
            begin
                state_next = CS_DONE;
            end
            CS_DONE:
            begin
                // Hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    `RBPP_ASSERT(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state_reg != CS_IDLE), "accepted item did not start a sequence")
    `RBPP_ASSERT(a_write_after_read, cmd.wr_plot |-> $past(cmd.rd_plot), "plot write without preceding read")
    `RBPP_ASSERT_NEVER(a_load_when_full, cmd.load_out && !status.out_free, "result loaded over a waiting result")

endmodule

[design/rbpp_datapath.sv]
// ----------------------------------------------------------------------------
// rbpp_datapath
// Configuration registers, coordinate rotation and address arithmetic, the
// three byte planes, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotated_bitplane_pixel_plotter_core_macros.svh"

module rbpp_datapath #(
    parameter int PANEL_WIDTH  = rbpp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = rbpp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rbpp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_index,
    input  logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rbpp_pkg::dp_cmd_t               cmd,
    output rbpp_pkg::dp_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rbpp_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rbpp_pkg::*;

    localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int AW = $clog2(PLANE_BYTES);
    localparam int XW = $clog2(PANEL_WIDTH);
    localparam int YW = $clog2(PANEL_HEIGHT);
    localparam int PW = YW + $clog2(PANEL_WIDTH + 1);
    localparam int IW = (AW > 14) ? AW + 1 : 15;

    // Configuration
    logic        mono_mode_reg;
    logic [1:0]  rotation_reg;

    // Captured item
    func_t       func_reg;
    logic [15:0] pos_x_reg;
    logic [15:0] pos_y_reg;
    logic [15:0] color_reg;
    logic [13:0] rindex_reg;

    // Plot address pipeline
    logic [15:0]   xn;
    logic [15:0]   yn;
    logic [15:0]   wrot;
    logic [15:0]   hrot;
    logic          in_bounds;
    logic [XW-1:0] xr_reg;
    logic [YW-1:0] yr_reg;
    logic          bounds_reg;
    logic [PW-1:0] prod_reg;
    logic [AW:0]   idx_sum;
    logic [AW-1:0] idx_reg;
    logic          idx_ok_reg;
    logic [2:0]    bitpos_reg;
    logic [7:0]    mask;

    // Planes
    logic [7:0]    mono_mem   [PLANE_BYTES];
    logic [7:0]    first_mem  [PLANE_BYTES];
    logic [7:0]    second_mem [PLANE_BYTES];
    logic [7:0]    rd_mono_reg;
    logic [7:0]    rd_first_reg;
    logic [7:0]    rd_second_reg;
    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] mem_addr;
    logic          rindex_ok;
    logic          mem_rd;
    logic          mono_we;
    logic          first_we;
    logic          second_we;
    logic [7:0]    mono_wdata;
    logic [7:0]    first_wdata;
    logic [7:0]    second_wdata;
    logic [7:0]    fill_a;
    logic [7:0]    gray_first;
    logic [7:0]    gray_second;
    logic [7:0]    plot_first;
    logic [7:0]    plot_second;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  res_written;
    logic [7:0]            res_mono;
    logic [7:0]            res_first;
    logic [7:0]            res_second;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_mode_reg <= 1'b1;
            rotation_reg  <= ROT_0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MONO_MODE)
            begin
                mono_mode_reg <= cfg_data[0];
            end
            else
            begin
                rotation_reg <= cfg_data[1:0];
            end
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func_t'(s_tuser);
            pos_x_reg  <= s_tdata[15:0];
            pos_y_reg  <= s_tdata[31:16];
            color_reg  <= s_tdata[47:32];
            rindex_reg <= s_tdata[61:48];
        end
    end

    // Bounds check against the rotated size, then rotate onto the panel
    always_comb
    begin
        wrot      = rotation_reg[0] ? 16'(PANEL_HEIGHT) : 16'(PANEL_WIDTH);
        hrot      = rotation_reg[0] ? 16'(PANEL_WIDTH) : 16'(PANEL_HEIGHT);
        in_bounds = !pos_x_reg[15] && !pos_y_reg[15] &&
                    (pos_x_reg < wrot) && (pos_y_reg < hrot);
        case (rotation_reg)
            ROT_90:
            begin
                xn = 16'(PANEL_WIDTH - 1) - pos_y_reg;
                yn = pos_x_reg;
            end
            ROT_180:
            begin
                xn = 16'(PANEL_WIDTH - 1) - pos_x_reg;
                yn = 16'(PANEL_HEIGHT - 1) - pos_y_reg;
            end
            ROT_270:
            begin
                xn = pos_y_reg;
                yn = 16'(PANEL_HEIGHT - 1) - pos_x_reg;
            end
            default:
            begin
                xn = pos_x_reg;
                yn = pos_y_reg;
            end
        endcase
    end

    // Byte index x/8 + y*W/8 over three register stages
    assign idx_sum = (AW + 1)'(xr_reg >> 3) + (AW + 1)'(prod_reg >> 3);

    always_ff @(posedge clk)
    begin
        if (cmd.rot_en)
        begin
            xr_reg <= XW'(xn);
            yr_reg <= YW'(yn);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(yr_reg) * PW'(PANEL_WIDTH);
        end
        if (cmd.addr_en)
        begin
            idx_reg    <= AW'(idx_sum);
            bitpos_reg <= xr_reg[2:0];
        end
    end

    // Plot flags are control: clear on reset so the plot gate is never unknown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg <= 1'b0;
            idx_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rot_en)
            begin
                bounds_reg <= in_bounds;
            end
            if (cmd.addr_en)
            begin
                idx_ok_reg <= idx_sum < (AW + 1)'(PLANE_BYTES);
            end
        end
    end

    assign mask = MASK_MSB >> bitpos_reg;

    // Fill sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            fill_cnt_reg <= '0;
        end
        else if (cmd.fill_wr)
        begin
            fill_cnt_reg <= fill_cnt_reg + AW'(1);
        end
    end

    // Fill bytes by colour
    always_comb
    begin
        fill_a      = (color_reg == COLOR_BLACK) ? BYTE_ONES : BYTE_ZEROS;
        gray_first  = BYTE_ZEROS;
        gray_second = BYTE_ZEROS;
        if (color_reg == COLOR_BLACK)
        begin
            gray_first  = BYTE_ONES;
            gray_second = BYTE_ONES;
        end
        else if (color_reg == COLOR_LIGHT)
        begin
            gray_first = BYTE_ONES;
        end
        else if (color_reg == COLOR_DARK)
        begin
            gray_second = BYTE_ONES;
        end
    end

    // Modified gray bytes for a plot
    always_comb
    begin
        case (color_reg[15:6])
            LEVEL_ONE:
            begin
                plot_first  = rd_first_reg & ~mask;
                plot_second = rd_second_reg | mask;
            end
            LEVEL_TWO:
            begin
                plot_first  = rd_first_reg | mask;
                plot_second = rd_second_reg & ~mask;
            end
            LEVEL_THREE:
            begin
                plot_first  = rd_first_reg & ~mask;
                plot_second = rd_second_reg & ~mask;
            end
            default:
            begin
                plot_first  = rd_first_reg | mask;
                plot_second = rd_second_reg | mask;
            end
        endcase
    end

    // Plane port control
    assign rindex_ok = IW'(rindex_reg) < IW'(PLANE_BYTES);
    assign mem_rd    = cmd.rd_plot | (cmd.rd_index & rindex_ok);

    always_comb
    begin
        if (cmd.fill_wr)
        begin
            mem_addr = fill_cnt_reg;
        end
        else if (cmd.rd_index)
        begin
            mem_addr = AW'(rindex_reg);
        end
        else
        begin
            mem_addr = idx_reg;
        end
        mono_we   = (cmd.fill_wr | cmd.wr_plot) & mono_mode_reg;
        first_we  = cmd.fill_wr | (cmd.wr_plot & !mono_mode_reg);
        second_we = (cmd.fill_wr | cmd.wr_plot) & !mono_mode_reg;
        if (cmd.fill_wr)
        begin
            mono_wdata   = fill_a;
            first_wdata  = mono_mode_reg ? fill_a : gray_first;
            second_wdata = gray_second;
        end
        else
        begin
            mono_wdata   = (color_reg != COLOR_BLACK) ? (rd_mono_reg & ~mask)
                                                      : (rd_mono_reg | mask);
            first_wdata  = plot_first;
            second_wdata = plot_second;
        end
    end

    // Byte planes: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mono_we)
        begin
            mono_mem[mem_addr] <= mono_wdata;
        end
        if (mem_rd)
        begin
            rd_mono_reg <= mono_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[mem_addr] <= first_wdata;
        end
        if (mem_rd)
        begin
            rd_first_reg <= first_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[mem_addr] <= second_wdata;
        end
        if (mem_rd)
        begin
            rd_second_reg <= second_mem[mem_addr];
        end
    end

    // Result of the finished item
    always_comb
    begin
        res_written = (func_reg == FUNC_PLOT) && bounds_reg && idx_ok_reg;
        if ((func_reg == FUNC_READ) && rindex_ok)
        begin
            res_mono   = rd_mono_reg;
            res_first  = rd_first_reg;
            res_second = rd_second_reg;
        end
        else
        begin
            res_mono   = BYTE_ZEROS;
            res_first  = BYTE_ZEROS;
            res_second = BYTE_ZEROS;
        end
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {7'd0, res_second, res_first, res_mono, res_written};
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;
    assign status.plot_ok   = bounds_reg && idx_ok_reg;
    assign status.fill_last = (fill_cnt_reg == AW'(PLANE_BYTES - 1));
    assign status.out_free  = !out_valid_reg || m_tready;

    `RBPP_ASSERT(a_plot_read_in_bounds, cmd.rd_plot |-> (bounds_reg && idx_ok_reg), "plane read for an out-of-bounds plot")
    `RBPP_ASSERT(a_load_sets_valid, cmd.load_out |=> out_valid_reg, "loaded result not presented")
    `RBPP_ASSERT(a_fill_in_range, cmd.fill_wr |-> (fill_cnt_reg < AW'(PLANE_BYTES)), "fill address beyond the planes")

endmodule

[design/rotated_bitplane_pixel_plotter_core.sv]
// ----------------------------------------------------------------------------
// rotated_bitplane_pixel_plotter_core
// Frame-buffer writer for a one-bit-per-pixel e-paper panel with a mono
// plane and two gray planes.
// ----------------------------------------------------------------------------
// Each item gives exactly one result, and items are handled one at a time.
// A plot steps through bounds and rotation, multiply, index add, plane read,
// plane write and result (an out-of-bounds plot skips the plane read and
// write), a read through plane read and result, and a fill walks the single
// write port of each plane one byte a cycle. A new item is taken while the
// previous result still waits in the output register. Plane contents are
// undefined until the first fill;
// configuration may only be written while no item is in progress.
`timescale 1ns / 1ps

module rotated_bitplane_pixel_plotter_core #(
    parameter int PANEL_WIDTH  = rbpp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = rbpp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[15:0], pos_y[31:16], color[47:32], read_index[61:48], zero pad
    input  logic [rbpp_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_written[0], mono_byte[8:1], first_plane_byte[16:9],
    // second_plane_byte[24:17], zero pad
    output logic [rbpp_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration writes: index 0 mono_mode, index 1 rotation
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbpp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers are always free to take a write
    assign cfg_ready = 1'b1;

    rbpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rbpp_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[dv/rotated_bitplane_pixel_plotter_core_checker.sv]
// ----------------------------------------------------------------------------
// rotated_bitplane_pixel_plotter_core_checker
// Watches the item, result and register channels of the bit-plane pixel
// plotter. It keeps its own copy of the three planes and of the mode and
// rotation registers, works out the result of every accepted item and
// compares each result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotated_bitplane_pixel_plotter_core_checker #(
    parameter int PANEL_WIDTH  = rbpp_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = rbpp_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // pos_x[15:0], pos_y[31:16], color[47:32], read_index[61:48], zero pad
    input  logic [rbpp_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_written[0], mono_byte[8:1], first_plane_byte[16:9],
    // second_plane_byte[24:17], zero pad
    input  logic [rbpp_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              awaited
);
    import rbpp_pkg::*;

    localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int AW          = $clog2(PLANE_BYTES);

    // Result item as it sits on m_tdata, lowest field last
    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
        logic [7:0] mono_byte;
        logic       written;
    } pixel_result_t;

    logic [7:0]    mono_mem   [PLANE_BYTES];
    logic [7:0]    first_mem  [PLANE_BYTES];
    logic [7:0]    second_mem [PLANE_BYTES];
    logic          mono_on;
    logic [1:0]    quarter_turns;
    pixel_result_t due_results [$];
    pixel_result_t want;
    pixel_result_t got;

    // Apply one item to the shadow planes and return the result it gives
    function automatic pixel_result_t render_item(input func_t op,
                                                  input logic signed [15:0] x_in,
                                                  input logic signed [15:0] y_in,
                                                  input logic [15:0] colour,
                                                  input logic [13:0] idx);
        pixel_result_t res;
        int            px;
        int            py;
        int            span_x;
        int            span_y;
        int            col;
        int            row;
        int            byte_at;
        logic [AW-1:0] at;
        logic [7:0]    mask;
        logic [7:0]    plane_a;
        logic [7:0]    plane_b;

        res = '0;
        case (op)
            FUNC_PLOT:
            begin
                px = int'(x_in);
                py = int'(y_in);
                span_x = quarter_turns[0] ? PANEL_HEIGHT : PANEL_WIDTH;
                span_y = quarter_turns[0] ? PANEL_WIDTH : PANEL_HEIGHT;
                if (px >= 0 && py >= 0 && px < span_x && py < span_y)
                begin
                    // Map the logical point onto the panel
                    case (quarter_turns)
                        ROT_90:
                        begin
                            col = PANEL_WIDTH - 1 - py;
                            row = px;
                        end
                        ROT_180:
                        begin
                            col = PANEL_WIDTH - 1 - px;
                            row = PANEL_HEIGHT - 1 - py;
                        end
                        ROT_270:
                        begin
                            col = py;
                            row = PANEL_HEIGHT - 1 - px;
                        end
                        default:
                        begin
                            col = px;
                            row = py;
                        end
                    endcase
                    byte_at = col / 8 + (row * PANEL_WIDTH) / 8;
                    if (byte_at < PLANE_BYTES)
                    begin
                        at = AW'(byte_at);
                        mask = MASK_MSB >> col[2:0];
                        res.written = 1'b1;
                        if (mono_on)
                        begin
                            // Black sets the bit, any other colour clears it
                            if (colour != COLOR_BLACK)
                                mono_mem[at] = mono_mem[at] & ~mask;
                            else
                                mono_mem[at] = mono_mem[at] | mask;
                        end
                        else
                        begin
                            case (colour[15:6])
                                LEVEL_ONE:
                                begin
                                    first_mem[at]  = first_mem[at] & ~mask;
                                    second_mem[at] = second_mem[at] | mask;
                                end
                                LEVEL_TWO:
                                begin
                                    first_mem[at]  = first_mem[at] | mask;
                                    second_mem[at] = second_mem[at] & ~mask;
                                end
                                LEVEL_THREE:
                                begin
                                    first_mem[at]  = first_mem[at] & ~mask;
                                    second_mem[at] = second_mem[at] & ~mask;
                                end
                                default:
                                begin
                                    first_mem[at]  = first_mem[at] | mask;
                                    second_mem[at] = second_mem[at] | mask;
                                end
                            endcase
                        end
                    end
                end
            end
            FUNC_FILL:
            begin
                if (mono_on)
                begin
                    // Mono fill covers the mono and first planes
                    plane_a = (colour == COLOR_BLACK) ? BYTE_ONES : BYTE_ZEROS;
                    for (int i = 0; i < PLANE_BYTES; i++)
                    begin
                        mono_mem[AW'(i)]  = plane_a;
                        first_mem[AW'(i)] = plane_a;
                    end
                end
                else
                begin
                    // Gray fill: named colours pick the two plane patterns
                    plane_a = BYTE_ZEROS;
                    plane_b = BYTE_ZEROS;
                    if (colour == COLOR_BLACK)
                    begin
                        plane_a = BYTE_ONES;
                        plane_b = BYTE_ONES;
                    end
                    else if (colour == COLOR_LIGHT)
                        plane_a = BYTE_ONES;
                    else if (colour == COLOR_DARK)
                        plane_b = BYTE_ONES;
                    for (int i = 0; i < PLANE_BYTES; i++)
                    begin
                        first_mem[AW'(i)]  = plane_a;
                        second_mem[AW'(i)] = plane_b;
                    end
                end
            end
            FUNC_READ:
            begin
                // Indexes beyond the planes read as zero
                if (idx < PLANE_BYTES)
                begin
                    res.mono_byte   = mono_mem[AW'(idx)];
                    res.first_byte  = first_mem[AW'(idx)];
                    res.second_byte = second_mem[AW'(idx)];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Report one field that differs from the prediction
    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     exp_val, act_val);
        end
    endtask

    // Track registers, compare results and predict new ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            mono_on = 1'b1;
            quarter_turns = ROT_0;
            fail_count = 0;
            awaited <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MONO_MODE)
                    mono_on = cfg_data[0];
                else
                    quarter_turns = cfg_data;
            end

            if (m_tvalid && m_tready)
            begin
                got = pixel_result_t'(m_tdata);
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result item %h with nothing expected", $time, m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("pixel_written", {7'd0, want.written}, {7'd0, got.written});
                    check_field("mono_byte", want.mono_byte, got.mono_byte);
                    check_field("first_plane_byte", want.first_byte, got.first_byte);
                    check_field("second_plane_byte", want.second_byte, got.second_byte);
                end
            end

            if (s_tvalid && s_tready)
                due_results.push_back(render_item(func_t'(s_tuser),
                                                  $signed(s_tdata[15:0]),
                                                  $signed(s_tdata[31:16]),
                                                  s_tdata[47:32],
                                                  s_tdata[61:48]));

            awaited <= due_results.size();
        end
    end

endmodule

[dv/rotated_bitplane_pixel_plotter_core_tb.sv]
// ----------------------------------------------------------------------------
// rotated_bitplane_pixel_plotter_core_tb
// Drives plot, fill, read and idle items into the bit-plane pixel plotter
// under every mode and rotation, with random gaps on both stream sides and
// one long result stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotated_bitplane_pixel_plotter_core_tb;
    import rbpp_pkg::*;

    localparam int W            = DEF_PANEL_WIDTH;
    localparam int H            = DEF_PANEL_HEIGHT;
    localparam int PLANE_BYTES  = (W * H + 7) / 8;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 8;
    localparam int TAIL_WAIT    = 16;
    localparam int STALL_LIMIT  = 60000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int         fail_count;
    int         awaited;
    int         tx_idle_pct = 18;
    int         rx_idle_pct = 56;
    logic       hold_arm    = 1'b0;
    logic       hold_done   = 1'b0;
    int         hold_left   = 0;
    int         stalled     = 0;
    logic [1:0] cur_rot     = ROT_0;
    int         hot_col     = 0;
    int         hot_row     = 0;

    always #5 clk = ~clk;

    rotated_bitplane_pixel_plotter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rotated_bitplane_pixel_plotter_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    // Result side: one long hold when armed, otherwise random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Drop the run if nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stalled <= 0;
        else if (stalled >= STALL_LIMIT)
        begin
            $display("rotated_bitplane_pixel_plotter_core_tb NOT OK");
            $finish;
        end
        else
            stalled <= stalled + 1;
    end

    // Offer one item after random idle cycles and hold it until taken
    task automatic offer(input func_t op, input logic [15:0] x, input logic [15:0] y,
                         input logic [15:0] colour, input logic [13:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx, colour, y, x};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // Write both registers back to back
    task automatic program_mode(input logic mono, input logic [1:0] rot);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MONO_MODE;
        cfg_data  <= {1'b0, mono};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_ROTATION;
        cfg_data  <= rot;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_rot = rot;
    endtask

    // Named colours, gray levels 0 to 3 with random low bits, or anything
    function automatic logic [15:0] pick_colour();
        case ($urandom_range(0, 9))
            0: return COLOR_BLACK;
            1: return COLOR_DARK;
            2: return COLOR_LIGHT;
            3: return 16'hFFFF;
            4, 5, 6, 7: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly plots and reads around a small hot window, plus noise and fills
    task automatic offer_random();
        int          pick;
        int          col;
        int          row;
        int          span_x;
        int          span_y;
        logic [15:0] x;
        logic [15:0] y;

        pick   = $urandom_range(0, 999);
        span_x = cur_rot[0] ? H : W;
        span_y = cur_rot[0] ? W : H;
        col    = hot_col + $urandom_range(0, 31);
        row    = hot_row + $urandom_range(0, 1);
        if (pick < 12)
            offer(FUNC_FILL, 16'($urandom), 16'($urandom), pick_colour(), 14'($urandom));
        else if (pick < 30)
            offer(FUNC_NOP, 16'($urandom), 16'($urandom), 16'($urandom), 14'($urandom));
        else if (pick < 600)
        begin
            // Turn a panel pixel of the hot window back into logical coordinates
            case (cur_rot)
                ROT_90:
                begin
                    x = 16'(row);
                    y = 16'(W - 1 - col);
                end
                ROT_180:
                begin
                    x = 16'(W - 1 - col);
                    y = 16'(H - 1 - row);
                end
                ROT_270:
                begin
                    x = 16'(H - 1 - row);
                    y = 16'(col);
                end
                default:
                begin
                    x = 16'(col);
                    y = 16'(row);
                end
            endcase
            offer(FUNC_PLOT, x, y, pick_colour(), 14'($urandom));
        end
        else if (pick < 700)
            offer(FUNC_PLOT, 16'($urandom_range(0, span_x - 1)),
                  16'($urandom_range(0, span_y - 1)), pick_colour(), 14'($urandom));
        else if (pick < 760)
            offer(FUNC_PLOT, 16'($urandom_range(span_x - 2, span_x)),
                  16'($urandom_range(span_y - 2, span_y)), pick_colour(), 14'($urandom));
        else if (pick < 800)
            offer(FUNC_PLOT, 16'($urandom), 16'($urandom), pick_colour(), 14'($urandom));
        else if (pick < 950)
            offer(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                  14'(col / 8 + row * W / 8));
        else
            offer(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), 14'($urandom));
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Define every plane before anything reads or plots into it
        settle();
        program_mode(1'b0, ROT_0);
        offer(FUNC_FILL, 16'h0000, 16'h0000, COLOR_DARK, 14'd0);
        settle();
        program_mode(1'b1, ROT_0);
        offer(FUNC_FILL, 16'h0000, 16'h0000, COLOR_BLACK, 14'd0);

        // Mono corners, out-of-range points, buffer edges, an idle item and a fill
        offer(FUNC_PLOT, 16'd0, 16'd0, 16'hFFFF, 14'd0);
        offer(FUNC_PLOT, 16'(W - 1), 16'(H - 1), 16'h0001, 14'd0);
        offer(FUNC_PLOT, 16'(W), 16'd0, COLOR_BLACK, 14'd0);
        offer(FUNC_PLOT, 16'd0, 16'(H), COLOR_BLACK, 14'd0);
        offer(FUNC_PLOT, 16'hFFFF, 16'd0, COLOR_BLACK, 14'd0);
        offer(FUNC_PLOT, 16'h8000, 16'h7FFF, COLOR_BLACK, 14'h3FFF);
        offer(FUNC_READ, 16'd0, 16'd0, 16'd0, 14'd0);
        offer(FUNC_READ, 16'd0, 16'd0, 16'd0, 14'(PLANE_BYTES - 1));
        offer(FUNC_READ, 16'd0, 16'd0, 16'd0, 14'(PLANE_BYTES));
        offer(FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
        offer(FUNC_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
        offer(FUNC_FILL, 16'd0, 16'd0, 16'hFFFF, 14'd0);

        // Every gray level in one byte, then the named gray fills
        settle();
        program_mode(1'b0, ROT_0);
        offer(FUNC_PLOT, 16'd8, 16'd0, 16'h0040, 14'd0);
        offer(FUNC_PLOT, 16'd9, 16'd0, 16'h0080, 14'd0);
        offer(FUNC_PLOT, 16'd10, 16'd0, 16'h00C0, 14'd0);
        offer(FUNC_PLOT, 16'd11, 16'd0, 16'h003F, 14'd0);
        offer(FUNC_PLOT, 16'd12, 16'd0, 16'hFFFF, 14'd0);
        offer(FUNC_READ, 16'd0, 16'd0, 16'd0, 14'd1);
        offer(FUNC_FILL, 16'd0, 16'd0, COLOR_LIGHT, 14'd0);
        offer(FUNC_FILL, 16'd0, 16'd0, COLOR_BLACK, 14'd0);

        // Swapped bounds under a quarter turn
        settle();
        program_mode(1'b0, ROT_270);
        offer(FUNC_PLOT, 16'(H - 1), 16'(W - 1), 16'h0040, 14'd0);
        offer(FUNC_PLOT, 16'd0, 16'(W), 16'h0040, 14'd0);
        offer(FUNC_READ, 16'd0, 16'd0, 16'd0, 14'((W - 1) / 8));

        // Random phases over all modes and rotations
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == 5)
            begin
                tx_idle_pct = 56;
                rx_idle_pct <= 18;
            end
            else if (p == 10)
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (p < 8)
                program_mode(p[0], p[2:1]);
            else
                program_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            hot_col = 8 * $urandom_range(0, W / 8 - 4);
            hot_row = $urandom_range(0, H - 2);
            if (p == 3)
                hold_arm <= 1'b1;
            repeat (PHASE_ITEMS) offer_random();
        end

        settle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("rotated_bitplane_pixel_plotter_core_tb OK");
        else
            $display("rotated_bitplane_pixel_plotter_core_tb NOT OK");
        $finish;
    end

endmodule
